@@ rtl/core/ifd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image frame deframer package
// Shared types, register indexes and constants of the deframer.
// ----------------------------------------------------------------------------
package ifd_pkg;

  localparam int HEADER_BYTES = 11;
  localparam int COUNTER_BITS = 32;

  localparam int HIDX_W = 4;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [HIDX_W-1:0] HIDX_TYPE    = HIDX_W'(0);
  localparam logic [HIDX_W-1:0] HIDX_ID_LO   = HIDX_W'(2);
  localparam logic [HIDX_W-1:0] HIDX_W_LO    = HIDX_W'(4);
  localparam logic [HIDX_W-1:0] HIDX_H_LO    = HIDX_W'(6);
  localparam logic [HIDX_W-1:0] HIDX_PRODUCT = HIDX_W'(7);
  localparam logic [HIDX_W-1:0] HIDX_LAST    = HIDX_W'(HEADER_BYTES - 1);

  localparam logic [7:0]  RESET_SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]  RESET_SYNC_SECOND = 8'h55;
  localparam logic [7:0]  RESET_FRAME_TYPE  = 8'h01;
  localparam logic [15:0] RESET_MAX_WIDTH   = 16'd640;
  localparam logic [15:0] RESET_MAX_HEIGHT  = 16'd480;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CHK_HI,
    PH_CHK_LO
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_GOOD,
    KIND_BAD_SUM,
    KIND_BAD_HDR
  } kind_t;

  typedef enum logic [2:0] {
    REG_SYNC_FIRST,
    REG_SYNC_SECOND,
    REG_FRAME_TYPE,
    REG_MAX_WIDTH,
    REG_MAX_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  frame_type;
    logic [15:0] max_width;
    logic [15:0] max_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  hdr_type;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] product;
    logic [31:0] length;
  } hdr_info_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pixel_byte;
    logic [15:0] frame_id;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] received_sum;
    logic [15:0] computed_sum;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
  } result_t;

endpackage

@@ rtl/core/ifd_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Register file behind the APB-style port, with read back.
// ----------------------------------------------------------------------------
module ifd_cfg_regs
  import ifd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= RESET_SYNC_FIRST;
      cfg.sync_second <= RESET_SYNC_SECOND;
      cfg.frame_type  <= RESET_FRAME_TYPE;
      cfg.max_width   <= RESET_MAX_WIDTH;
      cfg.max_height  <= RESET_MAX_HEIGHT;
    end else if (wr_en) begin
      unique case (idx)
        REG_SYNC_FIRST:  cfg.sync_first  <= pwdata[7:0];
        REG_SYNC_SECOND: cfg.sync_second <= pwdata[7:0];
        REG_FRAME_TYPE:  cfg.frame_type  <= pwdata[7:0];
        REG_MAX_WIDTH:   cfg.max_width   <= pwdata[15:0];
        REG_MAX_HEIGHT:  cfg.max_height  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SYNC_FIRST:  prdata = CFG_DATA_W'(cfg.sync_first);
      REG_SYNC_SECOND: prdata = CFG_DATA_W'(cfg.sync_second);
      REG_FRAME_TYPE:  prdata = CFG_DATA_W'(cfg.frame_type);
      REG_MAX_WIDTH:   prdata = CFG_DATA_W'(cfg.max_width);
      REG_MAX_HEIGHT:  prdata = CFG_DATA_W'(cfg.max_height);
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/ifd_hdr_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer header check
// Decides whether a complete header describes an acceptable frame.
// ----------------------------------------------------------------------------
module ifd_hdr_check
  import ifd_pkg::*;
(
  input  hdr_info_t hdr,
  input  cfg_t      cfg,
  output logic      ok
);

  logic dims_ok;
  logic len_ok;

  // The product of width and height is registered earlier; the payload is
  // two bytes per pixel.
  assign dims_ok = (hdr.width != '0) && (hdr.height != '0) &&
                   (hdr.width <= cfg.max_width) && (hdr.height <= cfg.max_height);
  assign len_ok  = {1'b0, hdr.length} == {hdr.product, 1'b0};
  assign ok      = dims_ok && len_ok && (hdr.hdr_type == cfg.frame_type);

endmodule

@@ rtl/core/ifd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer parser
// Sync hunt, header capture, payload pass and checksum state machine.
// ----------------------------------------------------------------------------
module ifd_parser
  import ifd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  phase_t                  phase, phase_next;
  logic [HIDX_W-1:0]       header_index, header_index_next;
  logic [7:0]              hdr_type, hdr_type_next;
  logic [15:0]             hdr_frame_id, hdr_frame_id_next;
  logic [15:0]             hdr_width, hdr_width_next;
  logic [15:0]             hdr_height, hdr_height_next;
  logic [31:0]             hdr_length, hdr_length_next;
  logic [31:0]             hdr_product, hdr_product_next;
  logic [31:0]             payload_left, payload_left_next;
  logic [15:0]             running_sum, running_sum_next;
  logic [7:0]              checksum_high, checksum_high_next;
  logic [COUNTER_BITS-1:0] good_count, good_count_next;
  logic [COUNTER_BITS-1:0] bad_count, bad_count_next;

  logic [15:0] sum_add;
  logic [15:0] rx_sum;
  logic        hdr_ok;
  hdr_info_t   hdr_info;

  assign hdr_info.hdr_type = hdr_type_next;
  assign hdr_info.width    = hdr_width;
  assign hdr_info.height   = hdr_height;
  assign hdr_info.product  = hdr_product;
  assign hdr_info.length   = hdr_length_next;

  ifd_hdr_check u_hdr_check (
    .hdr (hdr_info),
    .cfg (cfg),
    .ok  (hdr_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      header_index  <= '0;
      hdr_type      <= '0;
      hdr_frame_id  <= '0;
      hdr_width     <= '0;
      hdr_height    <= '0;
      hdr_length    <= '0;
      hdr_product   <= '0;
      payload_left  <= '0;
      running_sum   <= '0;
      checksum_high <= '0;
      good_count    <= '0;
      bad_count     <= '0;
    end else begin
      phase         <= phase_next;
      header_index  <= header_index_next;
      hdr_type      <= hdr_type_next;
      hdr_frame_id  <= hdr_frame_id_next;
      hdr_width     <= hdr_width_next;
      hdr_height    <= hdr_height_next;
      hdr_length    <= hdr_length_next;
      hdr_product   <= hdr_product_next;
      payload_left  <= payload_left_next;
      running_sum   <= running_sum_next;
      checksum_high <= checksum_high_next;
      good_count    <= good_count_next;
      bad_count     <= bad_count_next;
    end
  end

  assign sum_add = running_sum + {8'h00, rx_byte};
  assign rx_sum  = {checksum_high, rx_byte};

  always_comb begin
    phase_next         = phase;
    header_index_next  = header_index;
    hdr_type_next      = hdr_type;
    hdr_frame_id_next  = hdr_frame_id;
    hdr_width_next     = hdr_width;
    hdr_height_next    = hdr_height;
    hdr_length_next    = hdr_length;
    hdr_product_next   = hdr_product;
    payload_left_next  = payload_left;
    running_sum_next   = running_sum;
    checksum_high_next = checksum_high;
    good_count_next    = good_count;
    bad_count_next     = bad_count;
    res_valid          = 1'b0;
    res.kind           = KIND_PIXEL;
    res.pixel_byte     = '0;
    res.received_sum   = '0;
    res.computed_sum   = '0;
    if (step) begin
      unique case (phase)
        PH_SYNC2: begin
          if (rx_byte == cfg.sync_second) begin
            running_sum_next  = sum_add;
            header_index_next = '0;
            phase_next        = PH_HEADER;
          end else if (rx_byte == cfg.sync_first) begin
            running_sum_next = {8'h00, rx_byte};
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_HEADER: begin
          running_sum_next = sum_add;
          if (header_index == HIDX_TYPE) begin
            hdr_type_next = rx_byte;
          end else if (header_index <= HIDX_ID_LO) begin
            hdr_frame_id_next = {hdr_frame_id[7:0], rx_byte};
          end else if (header_index <= HIDX_W_LO) begin
            hdr_width_next = {hdr_width[7:0], rx_byte};
          end else if (header_index <= HIDX_H_LO) begin
            hdr_height_next = {hdr_height[7:0], rx_byte};
          end else begin
            hdr_length_next = {hdr_length[23:0], rx_byte};
          end
          // Width and height are complete here, so the product is formed
          // while the length bytes still arrive.
          if (header_index == HIDX_PRODUCT) begin
            hdr_product_next = 32'(hdr_width) * 32'(hdr_height);
          end
          if (header_index != HIDX_LAST) begin
            header_index_next = header_index + HIDX_W'(1);
          end else begin
            header_index_next = '0;
            if (!hdr_ok) begin
              bad_count_next = bad_count + COUNTER_BITS'(1);
              phase_next     = PH_HUNT;
              res_valid      = 1'b1;
              res.kind       = KIND_BAD_HDR;
            end else begin
              payload_left_next = hdr_length_next;
              phase_next = (hdr_length_next == '0) ? PH_CHK_HI : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          running_sum_next  = sum_add;
          payload_left_next = payload_left - 32'd1;
          if (payload_left_next == '0) begin
            phase_next = PH_CHK_HI;
          end
          res_valid      = 1'b1;
          res.kind       = KIND_PIXEL;
          res.pixel_byte = rx_byte;
        end
        PH_CHK_HI: begin
          checksum_high_next = rx_byte;
          phase_next         = PH_CHK_LO;
        end
        PH_CHK_LO: begin
          if (rx_sum == running_sum) begin
            good_count_next = good_count + COUNTER_BITS'(1);
            res.kind        = KIND_GOOD;
          end else begin
            bad_count_next = bad_count + COUNTER_BITS'(1);
            res.kind       = KIND_BAD_SUM;
          end
          phase_next       = PH_HUNT;
          res_valid        = 1'b1;
          res.received_sum = rx_sum;
          res.computed_sum = running_sum;
        end
        default: begin
          if (rx_byte == cfg.sync_first) begin
            running_sum_next = {8'h00, rx_byte};
            phase_next       = PH_SYNC2;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      endcase
    end
    res.frame_id    = hdr_frame_id_next;
    res.width       = hdr_width_next;
    res.height      = hdr_height_next;
    res.good_frames = 32'(good_count_next);
    res.bad_frames  = 32'(bad_count_next);
  end

endmodule

@@ rtl/core/image_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image frame deframer
// Finds sync, checks the header, passes payload bytes and checks the frame
// checksum of a received byte stream.
//
//   Channel   Direction  Item
//   s_axis    in         one received byte (s_tdata)
//   m_axis    out        one result: kind on m_tuser, fields on m_tdata
//   APB       in/out     five configuration registers at 4*i
//
// One byte is taken in every cycle unless the output stalls; a byte waits in
// the input register; its result is presented in the following cycle.
// The input register and the output register decouple the two sides, so a
// stalled result blocks input only once both registers are full.
// Reset is synchronous and returns all but the byte and result data registers
// to their defaults, with the parser hunting for the first sync byte.
// ----------------------------------------------------------------------------
module image_frame_deframer
  import ifd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pixel_byte, frame_id, width, height, received_sum, computed_sum,
  // good_frames, bad_frames
  output logic [151:0]          m_tdata,
  output logic [1:0]            m_tuser,   // result_kind
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  ifd_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  ifd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {out_res.bad_frames, out_res.good_frames, out_res.computed_sum,
                    out_res.received_sum, out_res.height, out_res.width,
                    out_res.frame_id, out_res.pixel_byte};

endmodule
